>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C master register transfer block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Input word modes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_BYTE  = 2'd3;

  // Completion status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_START_FAIL = 2'd1;
  localparam logic [1:0] STATUS_NACK       = 2'd2;

  // Byte context inside the transmit phases.
  localparam logic [1:0] CTX_ADDRW = 2'd0;
  localparam logic [1:0] CTX_REG   = 2'd1;
  localparam logic [1:0] CTX_DATA  = 2'd2;
  localparam logic [1:0] CTX_ADDRR = 2'd3;

  // Bits in a byte.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Sequencer steps. Each transmit byte has four steps: SCL low and SCL high
  // with a data bit on SDA, repeated for all eight bits, then SCL low and
  // SCL high with SDA released for the acknowledge.
  typedef enum logic [4:0] {
    S_IDLE   = 5'd0,
    S_SA     = 5'd1,
    S_SB     = 5'd2,
    S_SC     = 5'd3,
    S_RSA    = 5'd4,
    S_RSB    = 5'd5,
    S_RSC    = 5'd6,
    S_TX_AW0 = 5'd7,
    S_TX_AW1 = 5'd8,
    S_TX_AW2 = 5'd9,
    S_TX_AW3 = 5'd10,
    S_TX_RG0 = 5'd11,
    S_TX_RG1 = 5'd12,
    S_TX_RG2 = 5'd13,
    S_TX_RG3 = 5'd14,
    S_TX_DT0 = 5'd15,
    S_TX_DT1 = 5'd16,
    S_TX_DT2 = 5'd17,
    S_TX_DT3 = 5'd18,
    S_TX_AR0 = 5'd19,
    S_TX_AR1 = 5'd20,
    S_TX_AR2 = 5'd21,
    S_TX_AR3 = 5'd22,
    S_RXL    = 5'd23,
    S_RXH    = 5'd24,
    S_RAL    = 5'd25,
    S_RAH    = 5'd26,
    S_PA     = 5'd27,
    S_PB     = 5'd28,
    S_PC     = 5'd29,
    S_WAIT   = 5'd30
  } step_t;

  // One input word.
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // One result word.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       want_write_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_read;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

>>> rtl/i2cm_in_if.sv
// ----------------------------------------------------------------------------
// i2cm_in_if
// Input channel: valid/ready handshake carrying one tick word.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] slave_address;
  logic [7:0] register_address;
  logic [7:0] byte_count;
  logic [7:0] write_byte;
  logic       sda_in;

  modport source (
    output valid, mode, slave_address, register_address, byte_count, write_byte, sda_in,
    input  ready
  );
  modport sink (
    input  valid, mode, slave_address, register_address, byte_count, write_byte, sda_in,
    output ready
  );
endinterface

>>> rtl/i2cm_out_if.sv
// ----------------------------------------------------------------------------
// i2cm_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       want_write_byte;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       last_read;
  logic       done_res;
  logic [1:0] status;

  modport source (
    output valid, scl_level, sda_level, want_write_byte, read_byte, read_valid,
           last_read, done_res, status,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, want_write_byte, read_byte, read_valid,
           last_read, done_res, status,
    output ready
  );
endinterface

>>> rtl/i2c_master_register_transfer.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// I2C master running register writes and reads, one bus tick per input word.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          contents
//   in_ch     sink       valid / ready      mode, addresses, count, data, SDA
//   out_ch    source     valid / ready      pin levels, read data, status
//   cfg       write      cfg_write          phase_ticks (16 bits)
//
// Every accepted word is one tick and yields exactly one result word, held
// in the output buffer from the cycle after acceptance and shown on out_ch
// once older results are taken. One word is taken every clock cycle while
// in_ch.ready is high. A two-entry output buffer lets a word be accepted
// while the previous result is still waiting; in_ch.ready falls only when
// both entries are occupied. Reset is synchronous and active high and
// leaves the bus idle with phase_ticks at one.
//
module i2c_master_register_transfer
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  // Configuration register: ticks per pin phase.
  logic [15:0] phase_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= 16'd1;
    end else if (cfg_write) begin
      phase_ticks <= cfg_data;
    end
  end

  // Input word gathered into one struct for the core.
  item_t   item;
  result_t result;
  logic    accept;
  logic    pop;

  assign item.mode             = in_ch.mode;
  assign item.slave_address    = in_ch.slave_address;
  assign item.register_address = in_ch.register_address;
  assign item.byte_count       = in_ch.byte_count;
  assign item.write_byte       = in_ch.write_byte;
  assign item.sda_in           = in_ch.sda_in;

  // Output buffer: a head entry facing the channel and one spare entry.
  result_t    head;
  result_t    spare;
  logic [1:0] fill;

  assign in_ch.ready = (fill != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  // The sequencer state moves only when a word is accepted, so a stalled
  // output freezes the bus timing along with it.
  i2cm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .item        (item),
    .phase_ticks (phase_ticks),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, accept} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if ((fill == 2'd0 && accept) || (fill == 2'd1 && accept && pop)) begin
      head <= result;
    end else if (fill == 2'd2 && pop) begin
      head <= spare;
    end
    if (fill == 2'd1 && accept && !pop) begin
      spare <= result;
    end
  end

  assign out_ch.valid           = (fill != 2'd0);
  assign out_ch.scl_level       = head.scl_level;
  assign out_ch.sda_level       = head.sda_level;
  assign out_ch.want_write_byte = head.want_write_byte;
  assign out_ch.read_byte       = head.read_byte;
  assign out_ch.read_valid      = head.read_valid;
  assign out_ch.last_read       = head.last_read;
  assign out_ch.done_res        = head.done_res;
  assign out_ch.status          = head.status;

endmodule

>>> rtl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Transfer sequencer: advances the bus state by one tick per accepted word.
// ----------------------------------------------------------------------------
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  item_t       item,
  input  logic [15:0] phase_ticks,
  output result_t     result
);

  step_t       step;
  logic [3:0]  bit_counter;
  logic [7:0]  shift_register;
  logic [7:0]  bytes_left;
  logic [6:0]  held_device_address;
  logic [7:0]  held_register_address;
  logic        is_read_transfer;
  logic [15:0] phase_timer;

  step_t       step_next;
  logic [3:0]  bit_counter_next;
  logic [7:0]  shift_register_next;
  logic [7:0]  bytes_left_next;
  logic [6:0]  held_device_address_next;
  logic [7:0]  held_register_address_next;
  logic        is_read_transfer_next;
  logic [15:0] phase_timer_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step                  <= S_IDLE;
      bit_counter           <= '0;
      shift_register        <= '0;
      bytes_left            <= '0;
      held_device_address   <= '0;
      held_register_address <= '0;
      is_read_transfer      <= 1'b0;
      phase_timer           <= '0;
    end else if (advance) begin
      step                  <= step_next;
      bit_counter           <= bit_counter_next;
      shift_register        <= shift_register_next;
      bytes_left            <= bytes_left_next;
      held_device_address   <= held_device_address_next;
      held_register_address <= held_register_address_next;
      is_read_transfer      <= is_read_transfer_next;
      phase_timer           <= phase_timer_next;
    end
  end

  always_comb begin
    step_t       s;
    logic [3:0]  bc;
    logic [7:0]  sr;
    logic [7:0]  bl;
    logic [6:0]  hda;
    logic [7:0]  hra;
    logic        rd;
    logic [15:0] pt;
    logic [15:0] limit;
    logic [4:0]  sv;
    logic [4:0]  off;
    logic [1:0]  ctx;
    logic [1:0]  ph;
    logic        is_tx;

    s   = step;
    bc  = bit_counter;
    sr  = shift_register;
    bl  = bytes_left;
    hda = held_device_address;
    hra = held_register_address;
    rd  = is_read_transfer;
    pt  = phase_timer;
    result = '0;

    // A begin or a supplied byte takes effect in this very tick.
    if (s == S_IDLE && (item.mode == MODE_WRITE || item.mode == MODE_READ)) begin
      hda = item.slave_address;
      hra = item.register_address;
      bl  = item.byte_count;
      rd  = (item.mode == MODE_READ);
      if (rd && bl == 8'd0) begin
        bl = 8'd1;
      end
      s  = S_SA;
      pt = '0;
    end else if (s == S_WAIT && item.mode == MODE_BYTE) begin
      bl = (bl != 8'd0) ? bl - 8'd1 : 8'd0;
      sr = item.write_byte;
      bc = BYTE_BITS;
      s  = S_TX_DT0;
      pt = '0;
    end

    sv    = s;
    off   = sv - S_TX_AW0;
    ctx   = off[3:2];
    ph    = off[1:0];
    is_tx = (s >= S_TX_AW0) && (s < S_RXL);

    // Pin levels of the phase in effect.
    result.scl_level = 1'b1;
    result.sda_level = 1'b1;
    if (is_tx) begin
      result.scl_level = ph[0];
      if (!ph[1]) begin
        result.sda_level = sr[7];
      end
    end else begin
      case (s)
        S_SA, S_RSA, S_WAIT: result.scl_level = 1'b0;
        S_SC, S_RSC:         result.sda_level = 1'b0;
        S_RXL:               result.scl_level = 1'b0;
        S_RAL: begin
          result.scl_level = 1'b0;
          result.sda_level = (bl <= 8'd1);
        end
        S_RAH:               result.sda_level = (bl <= 8'd1);
        S_PA: begin
          result.scl_level = 1'b0;
          result.sda_level = 1'b0;
        end
        S_PB:                result.sda_level = 1'b0;
        default: ;
      endcase
    end

    limit = (phase_ticks != 16'd0) ? phase_ticks : 16'd1;

    if (s == S_WAIT) begin
      result.want_write_byte = 1'b1;
    end else if (s != S_IDLE) begin
      pt = pt + 16'd1;
      if (pt >= limit) begin
        pt = '0;
        if (is_tx) begin
          unique case (ph)
            2'd0, 2'd2: s = step_t'(sv + 5'd1);
            2'd1: begin
              sr = {sr[6:0], 1'b0};
              bc = bc - 4'd1;
              s  = (bc == 4'd0) ? step_t'(sv + 5'd1) : step_t'(sv - 5'd1);
            end
            default: begin
              if (item.sda_in && ctx != CTX_ADDRR) begin
                bc = {2'b00, STATUS_NACK};
                s  = S_PA;
              end else if (ctx == CTX_ADDRW) begin
                sr = hra;
                bc = BYTE_BITS;
                s  = S_TX_RG0;
              end else if (ctx == CTX_REG && rd) begin
                s = S_RSA;
              end else if (ctx == CTX_ADDRR) begin
                bc = BYTE_BITS;
                s  = S_RXL;
              end else if (bl != 8'd0) begin
                s = S_WAIT;
              end else begin
                bc = {2'b00, STATUS_OK};
                s  = S_PA;
              end
            end
          endcase
        end else begin
          case (s)
            S_SA: s = S_SB;
            S_SB: begin
              if (!item.sda_in) begin
                result.done_res = 1'b1;
                result.status   = STATUS_START_FAIL;
                s = S_IDLE;
              end else begin
                s = S_SC;
              end
            end
            S_SC: begin
              if (item.sda_in) begin
                result.done_res = 1'b1;
                result.status   = STATUS_START_FAIL;
                s = S_IDLE;
              end else begin
                sr = {hda, 1'b0};
                bc = BYTE_BITS;
                s  = S_TX_AW0;
              end
            end
            S_RSA: s = S_RSB;
            S_RSB: s = S_RSC;
            S_RSC: begin
              sr = {hda, 1'b1};
              bc = BYTE_BITS;
              s  = S_TX_AR0;
            end
            S_RXL: s = S_RXH;
            S_RAL: s = S_RAH;
            S_RXH: begin
              sr = {sr[6:0], item.sda_in};
              bc = bc - 4'd1;
              if (bc == 4'd0) begin
                result.read_byte  = sr;
                result.read_valid = 1'b1;
                result.last_read  = (bl <= 8'd1);
                s = S_RAL;
              end else begin
                s = S_RXL;
              end
            end
            S_RAH: begin
              bl = (bl != 8'd0) ? bl - 8'd1 : 8'd0;
              if (bl == 8'd0) begin
                bc = {2'b00, STATUS_OK};
                s  = S_PA;
              end else begin
                bc = BYTE_BITS;
                s  = S_RXL;
              end
            end
            S_PA: s = S_PB;
            S_PB: s = S_PC;
            default: begin
              // End of the stop condition: report the code held in the counter.
              result.done_res = 1'b1;
              result.status   = bc[1:0];
              s = S_IDLE;
            end
          endcase
        end
      end
    end

    step_next                  = s;
    bit_counter_next           = bc;
    shift_register_next        = sr;
    bytes_left_next            = bl;
    held_device_address_next   = hda;
    held_register_address_next = hra;
    is_read_transfer_next      = rd;
    phase_timer_next           = pt;
  end

endmodule

>>> rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master register transfer block.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       want_write_byte,
  input logic [7:0] read_byte,
  input logic       read_valid,
  input logic       last_read,
  input logic       done_res,
  input logic [1:0] status
);

  // After a word is accepted, a result is always waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no result");

  // A stalled result stays offered.
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  // Status is only reported with the end of a transfer.
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (status == 2'd0))
    else $error("status without end of transfer");

  // Read data fields are zero unless a byte has just completed.
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid) |-> (read_byte == 8'd0 && !last_read))
    else $error("read data without a completed byte");

  // While waiting for write data, SCL is held low and SDA released.
  a_wait_pins: assert property (@(posedge clk) disable iff (rst)
    (out_valid && want_write_byte) |-> (!scl_level && sda_level))
    else $error("wrong pin levels while waiting for data");

endmodule

bind i2c_master_register_transfer i2cm_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .scl_level       (out_ch.scl_level),
  .sda_level       (out_ch.sda_level),
  .want_write_byte (out_ch.want_write_byte),
  .read_byte       (out_ch.read_byte),
  .read_valid      (out_ch.read_valid),
  .last_read       (out_ch.last_read),
  .done_res        (out_ch.done_res),
  .status          (out_ch.status)
);

>>> verif/i2c_master_register_transfer_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_tb
// Self-checking bench for the I2C master register transfer block. A model of
// the bus sequencer, kept in step with every accepted tick word, predicts the
// result word for each tick. A simple device model chooses the sampled SDA
// level so that start checks, acknowledges and read data follow real bus
// behaviour, with deliberate faults mixed in. Both channels stall at random.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_tb;
  import i2cm_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned.
  // The longest deliberate hold-off is the receiver's LONG_HOLD stall.
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_WORDS     = 100;
  localparam int LONG_HOLD        = 300;
  localparam int LONG_PHASE_TICKS = 20;
  localparam int NO_NACK          = -1;
  localparam int PRINT_LIMIT      = 40;

  // How the device model misbehaves around the start condition.
  typedef enum int {FAULT_NONE, FAULT_HELD_LOW, FAULT_STAYS_HIGH} start_fault_t;
  // What the device model returns on read data bits.
  typedef enum int {RX_RANDOM, RX_ZEROS, RX_ONES} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_register_transfer uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer model. These variables mirror the block's state after every
  // accepted word; the stimulus also reads them to decide what to send next.
  // --------------------------------------------------------------------------
  step_t       bus_step    = S_IDLE;
  logic [3:0]  bit_cnt     = '0;
  logic [7:0]  shift_byte  = '0;
  logic [7:0]  bytes_to_go = '0;
  logic [6:0]  dev_addr    = '0;
  logic [7:0]  held_reg    = '0;
  logic        read_xfer   = 1'b0;
  logic [15:0] phase_count = '0;
  logic [15:0] phase_len   = 16'd1;

  // Results the block still owes, oldest first.
  result_t bus_results_due[$];
  // Data bytes to hand over on the next write byte requests, before random.
  logic [7:0] write_data_q[$];

  // Knobs for the device model and the stimulus.
  start_fault_t slave_fault     = FAULT_NONE;
  rx_pattern_t  slave_rx        = RX_RANDOM;
  int           slave_nack_ctx  = NO_NACK;
  int           slave_noise_pct = 0;
  int           stray_pct       = 0;
  bit           idling_on       = 1'b1;
  int           sink_hold       = 0;

  // Bookkeeping.
  int errors        = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int transfers     = 0;
  int ends_ok       = 0;
  int ends_startbad = 0;
  int ends_nack     = 0;
  int bytes_read    = 0;

  // Loading a byte into the shifter enters the first phase of that byte.
  function automatic void load_byte(logic [7:0] b, logic [1:0] ctx);
    shift_byte = b;
    bit_cnt    = BYTE_BITS;
    bus_step   = step_t'(S_TX_AW0 + {ctx, 2'b00});
  endfunction

  // The stop sequence carries the final status in the bit counter.
  function automatic void begin_stop(logic [1:0] code);
    bit_cnt  = {2'b00, code};
    bus_step = S_PA;
  endfunction

  // Pin drive of the phase now in effect, as {scl, sda}.
  function automatic logic [1:0] pin_levels();
    logic       scl, sda;
    logic [4:0] off;
    scl = 1'b1;
    sda = 1'b1;
    off = bus_step - S_TX_AW0;
    case (bus_step)
      S_SA, S_RSA, S_WAIT: scl = 1'b0;
      S_SC, S_RSC:         sda = 1'b0;
      S_RXL:               scl = 1'b0;
      S_RAL: begin
        scl = 1'b0;
        sda = (bytes_to_go <= 8'd1);
      end
      S_RAH:               sda = (bytes_to_go <= 8'd1);
      S_PA: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      S_PB:                sda = 1'b0;
      default: begin
        if (bus_step >= S_TX_AW0 && bus_step < S_RXL) begin
          scl = off[0];
          if (off[1:0] < 2'd2) sda = shift_byte[7];
        end
      end
    endcase
    return {scl, sda};
  endfunction

  // Advances the model by one accepted tick word and returns its result.
  function automatic result_t advance_bus(item_t w);
    result_t     r;
    logic [1:0]  pins;
    logic [4:0]  off;
    logic [1:0]  ctx;
    logic [15:0] lim;
    r = '0;
    // A begin only counts when idle, a data byte only while one is requested;
    // either one restarts the phase timer on this very tick.
    if (bus_step == S_IDLE && (w.mode == MODE_WRITE || w.mode == MODE_READ)) begin
      dev_addr    = w.slave_address;
      held_reg    = w.register_address;
      bytes_to_go = w.byte_count;
      read_xfer   = (w.mode == MODE_READ);
      // A read of nothing still fetches one byte.
      if (read_xfer && bytes_to_go == 8'd0) bytes_to_go = 8'd1;
      bus_step    = S_SA;
      phase_count = '0;
    end else if (bus_step == S_WAIT && w.mode == MODE_BYTE) begin
      bytes_to_go = (bytes_to_go != 8'd0) ? bytes_to_go - 8'd1 : 8'd0;
      load_byte(w.write_byte, CTX_DATA);
      phase_count = '0;
    end
    pins = pin_levels();
    r.scl_level = pins[1];
    r.sda_level = pins[0];
    if (bus_step == S_WAIT) begin
      r.want_write_byte = 1'b1;
    end else if (bus_step != S_IDLE) begin
      // A phase length of zero behaves as one.
      lim = (phase_len != 16'd0) ? phase_len : 16'd1;
      phase_count = phase_count + 16'd1;
      if (phase_count >= lim) begin
        phase_count = '0;
        off = bus_step - S_TX_AW0;
        ctx = off[3:2];
        case (bus_step)
          S_SA: bus_step = S_SB;
          S_SB, S_SC: begin
            // The line must be high before the start and follow it low.
            if ((bus_step == S_SB && !w.sda_in) || (bus_step == S_SC && w.sda_in)) begin
              r.done_res = 1'b1;
              r.status   = STATUS_START_FAIL;
              bus_step   = S_IDLE;
            end else if (bus_step == S_SB) begin
              bus_step = S_SC;
            end else begin
              load_byte({dev_addr, 1'b0}, CTX_ADDRW);
            end
          end
          // The repeated start is not checked against the line.
          S_RSA, S_RSB, S_RXL, S_RAL, S_PA, S_PB: bus_step = step_t'(bus_step + 5'd1);
          S_RSC: load_byte({dev_addr, 1'b1}, CTX_ADDRR);
          S_RXH: begin
            shift_byte = {shift_byte[6:0], w.sda_in};
            bit_cnt    = bit_cnt - 4'd1;
            if (bit_cnt == 4'd0) begin
              r.read_byte  = shift_byte;
              r.read_valid = 1'b1;
              r.last_read  = (bytes_to_go <= 8'd1);
              bus_step     = S_RAL;
            end else begin
              bus_step = S_RXL;
            end
          end
          S_RAH: begin
            bytes_to_go = (bytes_to_go != 8'd0) ? bytes_to_go - 8'd1 : 8'd0;
            if (bytes_to_go == 8'd0) begin
              begin_stop(STATUS_OK);
            end else begin
              bit_cnt  = BYTE_BITS;
              bus_step = S_RXL;
            end
          end
          default: begin
            if (bus_step >= S_TX_AW0 && bus_step < S_RXL) begin
              case (off[1:0])
                2'd0, 2'd2: bus_step = step_t'(bus_step + 5'd1);
                2'd1: begin
                  shift_byte = {shift_byte[6:0], 1'b0};
                  bit_cnt    = bit_cnt - 4'd1;
                  bus_step   = (bit_cnt == 4'd0) ? step_t'(bus_step + 5'd1)
                                                 : step_t'(bus_step - 5'd1);
                end
                default: begin
                  // Acknowledge slot; after address+R it is not looked at.
                  if (w.sda_in && ctx != CTX_ADDRR) begin
                    begin_stop(STATUS_NACK);
                  end else if (ctx == CTX_ADDRW) begin
                    load_byte(held_reg, CTX_REG);
                  end else if (ctx == CTX_REG && read_xfer) begin
                    bus_step = S_RSA;
                  end else if (ctx == CTX_ADDRR) begin
                    bit_cnt  = BYTE_BITS;
                    bus_step = S_RXL;
                  end else if (bytes_to_go != 8'd0) begin
                    bus_step = S_WAIT;
                  end else begin
                    begin_stop(STATUS_OK);
                  end
                end
              endcase
            end else begin
              // End of the stop sequence.
              r.done_res = 1'b1;
              r.status   = bit_cnt[1:0];
              bus_step   = S_IDLE;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Device model: the SDA level the block samples on the next tick. Mostly the
  // line follows the master's drive; the device acknowledges, returns read
  // bits, and misbehaves as the knobs ask.
  // --------------------------------------------------------------------------
  function automatic logic slave_sda();
    logic       s;
    logic [1:0] pins;
    logic [4:0] off;
    pins = pin_levels();
    s    = pins[0];
    off  = bus_step - S_TX_AW0;
    if (bus_step == S_SB) begin
      s = (slave_fault != FAULT_HELD_LOW);
    end else if (bus_step == S_SC) begin
      s = (slave_fault == FAULT_STAYS_HIGH);
    end else if (bus_step == S_RXH) begin
      case (slave_rx)
        RX_ZEROS: s = 1'b0;
        RX_ONES:  s = 1'b1;
        default:  s = 1'($urandom_range(0, 1));
      endcase
    end else if (bus_step >= S_TX_AW0 && bus_step < S_RXL && off[1:0] == 2'd3) begin
      s = (int'(off[3:2]) == slave_nack_ctx);
    end
    if ($urandom_range(0, 99) < slave_noise_pct) s = !s;
    return s;
  endfunction

  // A plain tick word with random content in the fields the block ignores.
  function automatic item_t bus_tick_word();
    item_t w;
    w.mode             = MODE_TICK;
    w.slave_address    = 7'($urandom);
    w.register_address = 8'($urandom);
    w.byte_count       = 8'($urandom);
    w.write_byte       = 8'($urandom);
    w.sda_in           = slave_sda();
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("tb: result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
  endtask

  // Offers one word, possibly after a short gap, and books its result once
  // it has been taken. Valid is left high for the next word.
  task automatic send_word(input item_t w);
    result_t r;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.mode             <= w.mode;
    in_ch.slave_address    <= w.slave_address;
    in_ch.register_address <= w.register_address;
    in_ch.byte_count       <= w.byte_count;
    in_ch.write_byte       <= w.write_byte;
    in_ch.sda_in           <= w.sda_in;
    do @(posedge clk); while (!in_ch.ready);
    r = advance_bus(w);
    bus_results_due.push_back(r);
    words_sent++;
    if (r.read_valid) bytes_read++;
    if (r.done_res) begin
      case (r.status)
        STATUS_OK:         ends_ok++;
        STATUS_START_FAIL: ends_startbad++;
        default:           ends_nack++;
      endcase
    end
  endtask

  // Stops offering words and waits until every result is in, then a little
  // longer in case the block is still busy with its last word.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_phase_len(input logic [15:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    phase_len = v;
  endtask

  // Keeps ticking until the model says the bus is idle, supplying data bytes
  // when asked and, if enabled, mixing in words the block should ignore.
  task automatic finish_transfer();
    item_t w;
    while (bus_step != S_IDLE) begin
      w = bus_tick_word();
      if (bus_step == S_WAIT) begin
        if ($urandom_range(0, 3) != 0) begin
          w.mode       = MODE_BYTE;
          w.write_byte = (write_data_q.size() != 0) ? write_data_q.pop_front()
                                                     : 8'($urandom);
        end
      end else if ($urandom_range(0, 99) < stray_pct) begin
        w.mode = 2'($urandom_range(1, 3));
      end
      send_word(w);
    end
    transfers++;
  endtask

  task automatic run_transfer(input logic [1:0] kind, input logic [6:0] dev,
                              input logic [7:0] rg, input logic [7:0] cnt);
    item_t w;
    w                  = bus_tick_word();
    w.mode             = kind;
    w.slave_address    = dev;
    w.register_address = rg;
    w.byte_count       = cnt;
    send_word(w);
    finish_transfer();
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Plain writes with extreme addresses and data, and a write with no data.
  task automatic test_writes();
    write_phase_len(16'd1);
    write_data_q = {8'h00, 8'hFF};
    run_transfer(MODE_WRITE, 7'h7F, 8'h00, 8'd2);
    run_transfer(MODE_WRITE, 7'h00, 8'hFF, 8'd0);
  endtask

  // Reads, including a read of zero bytes that still fetches one.
  task automatic test_reads();
    slave_rx = RX_ONES;
    run_transfer(MODE_READ, 7'h55, 8'h80, 8'd0);
    slave_rx = RX_ZEROS;
    run_transfer(MODE_READ, 7'h2A, 8'h01, 8'd2);
    slave_rx = RX_RANDOM;
  endtask

  // SDA held low before the start, then SDA failing to follow the start.
  task automatic test_start_failures();
    slave_fault = FAULT_HELD_LOW;
    run_transfer(MODE_WRITE, 7'h12, 8'h34, 8'd1);
    slave_fault = FAULT_STAYS_HIGH;
    run_transfer(MODE_READ, 7'h56, 8'h78, 8'd1);
    slave_fault = FAULT_NONE;
  endtask

  // Missing acknowledge at each point where it is checked, and one after
  // address+R, where it is ignored.
  task automatic test_missing_acks();
    slave_nack_ctx = int'(CTX_ADDRW);
    run_transfer(MODE_WRITE, 7'h11, 8'h22, 8'hFF);
    slave_nack_ctx = int'(CTX_REG);
    run_transfer(MODE_READ, 7'h33, 8'h44, 8'hFF);
    slave_nack_ctx = int'(CTX_DATA);
    run_transfer(MODE_WRITE, 7'h66, 8'h77, 8'd3);
    slave_nack_ctx = int'(CTX_ADDRR);
    run_transfer(MODE_READ, 7'h19, 8'h5A, 8'd1);
    slave_nack_ctx = NO_NACK;
  endtask

  // A data byte and a tick while idle, then begins while busy and data bytes
  // that arrive when none is requested.
  task automatic test_stray_words();
    item_t w;
    w      = bus_tick_word();
    w.mode = MODE_BYTE;
    send_word(w);
    send_word(bus_tick_word());
    stray_pct = 25;
    run_transfer(MODE_WRITE, 7'h3C, 8'hC3, 8'd2);
    run_transfer(MODE_READ, 7'h43, 8'h3C, 8'd1);
    stray_pct = 0;
  endtask

  // Phase length of zero (acts as one), a length of two, and the longest,
  // where a transfer is begun and left part way through its first phase
  // before the length is shortened and the transfer run to its end.
  task automatic test_phase_lengths();
    item_t w;
    write_phase_len(16'd0);
    run_transfer(MODE_WRITE, 7'h21, 8'h12, 8'd1);
    write_phase_len(16'd2);
    run_transfer(MODE_READ, 7'h61, 8'h16, 8'd1);
    write_phase_len(16'hFFFF);
    idling_on          = 1'b0;
    w                  = bus_tick_word();
    w.mode             = MODE_WRITE;
    w.slave_address    = 7'h70;
    w.register_address = 8'h07;
    w.byte_count       = 8'd1;
    send_word(w);
    repeat (LONG_PHASE_TICKS) send_word(bus_tick_word());
    write_phase_len(16'd1);
    idling_on = 1'b1;
    finish_transfer();
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // output buffer fills and the input channel must stall.
  task automatic test_backpressure();
    idling_on = 1'b0;
    sink_hold = LONG_HOLD;
    run_transfer(MODE_WRITE, 7'h4D, 8'hD4, 8'd2);
    idling_on = 1'b1;
  endtask

  // Mostly well-formed transfers with random content, occasionally with a
  // long count cut short by a missing acknowledge, a failed start, stray
  // words and line noise.
  task automatic test_random();
    int          first;
    logic [1:0]  kind;
    logic [7:0]  cnt;
    first           = words_sent;
    stray_pct       = 5;
    while (words_sent - first < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_phase_len(16'd0);
          4:       write_phase_len(16'd2);
          5:       write_phase_len(16'd3);
          default: write_phase_len(16'd1);
        endcase
      end
      idling_on   = ($urandom_range(0, 3) != 0);
      kind        = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
      slave_fault = ($urandom_range(0, 11) == 0) ? start_fault_t'($urandom_range(1, 2))
                                                 : FAULT_NONE;
      if ($urandom_range(0, 9) == 0) begin
        cnt             = 8'($urandom);
        slave_nack_ctx  = $urandom_range(0, 1) ? int'(CTX_ADDRW) : int'(CTX_REG);
        slave_noise_pct = 0;
      end else begin
        cnt             = 8'($urandom_range(0, 3));
        slave_nack_ctx  = NO_NACK;
        slave_noise_pct = 2;
      end
      run_transfer(kind, 7'($urandom), 8'($urandom), cnt);
    end
    slave_fault     = FAULT_NONE;
    slave_nack_ctx  = NO_NACK;
    slave_noise_pct = 0;
    stray_pct       = 0;
  endtask

  // The last transfers run with both channels flowing freely.
  task automatic test_closing_flow();
    write_phase_len(16'd1);
    idling_on = 1'b0;
    write_data_q = {8'hA5};
    run_transfer(MODE_WRITE, 7'h5A, 8'hA5, 8'd1);
    run_transfer(MODE_READ, 7'h25, 8'h52, 8'd2);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: takes result words, with random hold-offs and, on request, one
  // long one. Ready is assigned once per clock edge.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Compares every taken result word with the oldest one still owed.
  initial begin : result_checker
    result_t got, want;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.scl_level       = out_ch.scl_level;
        got.sda_level       = out_ch.sda_level;
        got.want_write_byte = out_ch.want_write_byte;
        got.read_byte       = out_ch.read_byte;
        got.read_valid      = out_ch.read_valid;
        got.last_read       = out_ch.last_read;
        got.done_res        = out_ch.done_res;
        got.status          = out_ch.status;
        if (bus_results_due.size() == 0) begin
          report_mismatch("arrived with nothing owed", got, 0);
        end else begin
          want = bus_results_due.pop_front();
          if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
          if (got.sda_level !== want.sda_level)
            report_mismatch("sda_level", got.sda_level, want.sda_level);
          if (got.want_write_byte !== want.want_write_byte)
            report_mismatch("want_write_byte", got.want_write_byte, want.want_write_byte);
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
          if (got.last_read !== want.last_read)
            report_mismatch("last_read", got.last_read, want.last_read);
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        end
        results_seen++;
      end
    end
  end

  // Ends the run if neither channel has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: no progress for %0d cycles, %0d results still owed",
             STALL_LIMIT, bus_results_due.size());
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_data               <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.mode             <= MODE_TICK;
    in_ch.slave_address    <= '0;
    in_ch.register_address <= '0;
    in_ch.byte_count       <= '0;
    in_ch.write_byte       <= '0;
    in_ch.sda_in           <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_writes();
    test_reads();
    test_start_failures();
    test_missing_acks();
    test_stray_words();
    test_phase_lengths();
    test_backpressure();
    test_random();
    test_closing_flow();

    settle();
    repeat (20) @(posedge clk);
    $display("tb: %0d tick words over %0d transfers, phase lengths 0 to 65535",
             words_sent, transfers);
    $display("tb: %0d clean ends, %0d failed starts, %0d missing acks, %0d bytes read",
             ends_ok, ends_startbad, ends_nack, bytes_read);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> i2c_master_register_transfer.f
rtl/i2cm_pkg.sv
rtl/i2cm_in_if.sv
rtl/i2cm_out_if.sv
rtl/i2cm_core.sv
rtl/i2c_master_register_transfer.sv
rtl/i2cm_checker.sv
verif/i2c_master_register_transfer_tb.sv
